### src/fvgp_pkg.sv
// Shared types, status codes and constants of the FAT volume geometry parser.
package fvgp_pkg;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_READ_BOOT = 3'd1;
    localparam logic [2:0] ST_BAD_MBR   = 3'd2;
    localparam logic [2:0] ST_NO_ID     = 3'd3;
    localparam logic [2:0] ST_BAD_SIG   = 3'd4;
    localparam logic [2:0] ST_BAD_JUMP  = 3'd5;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd6;

    localparam logic [63:0] ID16_TEXT = "FAT16   ";
    localparam logic [63:0] ID32_TEXT = "FAT32   ";
    localparam logic [8:0]  ID16_OFS  = 9'h036;
    localparam logic [8:0]  ID32_OFS  = 9'h052;
    localparam logic [8:0]  OFS_FIRST = 9'd0;
    localparam logic [8:0]  OFS_SIG_HI = 9'd510;
    localparam logic [8:0]  OFS_LAST  = 9'd511;

    localparam logic [15:0] BOOT_SIG   = 16'h55AA;
    localparam logic [7:0]  JMP_NEAR   = 8'hE9;
    localparam logic [7:0]  JMP_SHORT  = 8'hEB;
    localparam logic [15:0] SECTOR_512 = 16'h0200;
    localparam logic [31:0] FIRST_CLUSTER = 32'd2;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic        is_volume;
        logic [2:0]  status;
        logic [31:0] lba;
        logic        id16;
        logic        id32;
        logic [7:0]  jump;
        logic [15:0] sec_bytes;
        logic [15:0] sig;
        logic [7:0]  spc;
        logic [15:0] rsvd;
        logic [7:0]  fat_copies;
        logic [15:0] root_entries;
        logic [15:0] fat16_size;
        logic [31:0] fat32_size;
        logic [27:0] root_clus;
    } t_job;

    function automatic logic [7:0] id_char(input logic [63:0] text, input logic [2:0] k);
        return text[8 * (7 - int'(k)) +: 8];
    endfunction

endpackage

### src/fat_volume_geometry_parser.sv
// Top level of the FAT volume geometry parser: byte capture, job queue and geometry back end.
// Throughput: one sector byte per cycle, sustained, while the result side keeps up.
// Each job passes through the job queue, then the stage-one register, then the output register.
// The two-entry job queue and two back-end stages absorb result-side stalls.
// Reset is synchronous and active low; captured fields clear and both identifier matches set.
module fat_volume_geometry_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_first_sector,
    input  logic [8:0]   i_offset,
    input  logic [7:0]   i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [2:0]   o_status,
    output logic [31:0]  o_next_lba,
    output logic         o_is_fat32,
    output logic [7:0]   o_clus_sectors,
    output logic [7:0]   o_clus_mask,
    output logic [31:0]  o_fat_lba,
    output logic [31:0]  o_data_lba,
    output logic [31:0]  o_root_dir_start,
    output logic [27:0]  o_root_dir_cluster,
    output logic [12:0]  o_root_dir_sectors,
    output logic [15:0]  o_root_ents,
    output logic         o_ready_res
);

    logic            w_fire;
    logic            w_push;
    logic            w_q_full;
    logic            w_q_valid;
    logic            w_pop;
    fvgp_pkg::t_job  w_front_job;
    fvgp_pkg::t_job  w_head_job;

    assign o_ready     = !w_q_full;
    assign w_fire      = i_valid && o_ready;
    assign o_ready_res = 1'b1;

    fvgp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_first_sector (i_first_sector),
        .i_offset       (i_offset),
        .i_data         (i_data),
        .o_push         (w_push),
        .o_job          (w_front_job)
    );

    fvgp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_head_job)
    );

    fvgp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (w_q_valid),
        .i_job              (w_head_job),
        .o_pop              (w_pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_next_lba         (o_next_lba),
        .o_is_fat32         (o_is_fat32),
        .o_clus_sectors     (o_clus_sectors),
        .o_clus_mask        (o_clus_mask),
        .o_fat_lba          (o_fat_lba),
        .o_data_lba         (o_data_lba),
        .o_root_dir_start   (o_root_dir_start),
        .o_root_dir_cluster (o_root_dir_cluster),
        .o_root_dir_sectors (o_root_dir_sectors),
        .o_root_ents        (o_root_ents)
    );

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("Job issued while the queue was full.");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("Queue popped while empty.");

    a_lba_only_on_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != fvgp_pkg::ST_READ_BOOT) |-> (o_next_lba == '0))
        else $error("Next LBA given without a boot sector request.");

    a_geometry_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != fvgp_pkg::ST_FOUND) |->
        (o_fat_lba == '0 && o_clus_sectors == '0 && o_root_ents == '0))
        else $error("Geometry given for a sector that was not accepted as a volume.");

    a_fat16_no_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_fat32) |-> (o_root_dir_cluster == '0))
        else $error("Root cluster given on a FAT16 volume.");

endmodule

### src/fvgp_front.sv
// Front end: captures sector bytes, tracks the boot-sector wait and issues one job per sector.
module fvgp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_first_sector,
    input  logic [8:0]         i_offset,
    input  logic [7:0]         i_data,
    output logic               o_push,
    output fvgp_pkg::t_job     o_job
);

    logic        r_awaiting, n_awaiting;
    logic [31:0] r_part_lba, n_part_lba;
    logic        r_id16, n_id16;
    logic        r_id32, n_id32;
    logic [7:0]  r_jump, n_jump;
    logic [15:0] r_sec_bytes, n_sec_bytes;
    logic [15:0] r_sig, n_sig;
    logic [7:0]  r_spc, n_spc;
    logic [15:0] r_rsvd, n_rsvd;
    logic [7:0]  r_fat_copies, n_fat_copies;
    logic [15:0] r_root_entries, n_root_entries;
    logic [15:0] r_fat16_size, n_fat16_size;
    logic [31:0] r_fat32_size, n_fat32_size;
    logic [27:0] r_root_clus, n_root_clus;
    logic [31:0] r_mbr_lba, n_mbr_lba;
    logic        w_take;
    logic [8:0]  w_k16, w_k32;

    assign w_take = i_fire && (i_first_sector || r_awaiting);
    assign w_k16  = i_offset - fvgp_pkg::ID16_OFS;
    assign w_k32  = i_offset - fvgp_pkg::ID32_OFS;

    always_comb begin
        n_awaiting     = r_awaiting;
        n_part_lba     = r_part_lba;
        n_id16         = r_id16;
        n_id32         = r_id32;
        n_jump         = r_jump;
        n_sec_bytes    = r_sec_bytes;
        n_sig          = r_sig;
        n_spc          = r_spc;
        n_rsvd         = r_rsvd;
        n_fat_copies   = r_fat_copies;
        n_root_entries = r_root_entries;
        n_fat16_size   = r_fat16_size;
        n_fat32_size   = r_fat32_size;
        n_root_clus    = r_root_clus;
        n_mbr_lba      = r_mbr_lba;
        o_push         = 1'b0;
        o_job          = '0;

        if (w_take) begin
            if (i_offset == fvgp_pkg::OFS_FIRST) begin
                n_id16 = 1'b1;
                n_id32 = 1'b1;
                n_jump = i_data;
            end
            if (w_k16 < 9'd8 &&
                i_data != fvgp_pkg::id_char(fvgp_pkg::ID16_TEXT, w_k16[2:0])) begin
                n_id16 = 1'b0;
            end
            if (w_k32 < 9'd8 &&
                i_data != fvgp_pkg::id_char(fvgp_pkg::ID32_TEXT, w_k32[2:0])) begin
                n_id32 = 1'b0;
            end
            case (i_offset)
                9'd11:  n_sec_bytes[7:0]     = i_data;
                9'd12:  n_sec_bytes[15:8]    = i_data;
                9'd13:  n_spc                = i_data;
                9'd14:  n_rsvd[7:0]          = i_data;
                9'd15:  n_rsvd[15:8]         = i_data;
                9'd16:  n_fat_copies         = i_data;
                9'd17:  n_root_entries[7:0]  = i_data;
                9'd18:  n_root_entries[15:8] = i_data;
                9'd22:  n_fat16_size[7:0]    = i_data;
                9'd23:  n_fat16_size[15:8]   = i_data;
                9'h024: n_fat32_size[7:0]    = i_data;
                9'h025: n_fat32_size[15:8]   = i_data;
                9'h026: n_fat32_size[23:16]  = i_data;
                9'h027: n_fat32_size[31:24]  = i_data;
                9'h02C: n_root_clus[7:0]     = i_data;
                9'h02D: n_root_clus[15:8]    = i_data;
                9'h02E: n_root_clus[23:16]   = i_data;
                9'h02F: n_root_clus[27:24]   = i_data[3:0];
                9'h1C6: n_mbr_lba[7:0]       = i_data;
                9'h1C7: n_mbr_lba[15:8]      = i_data;
                9'h1C8: n_mbr_lba[23:16]     = i_data;
                9'h1C9: n_mbr_lba[31:24]     = i_data;
                fvgp_pkg::OFS_SIG_HI: n_sig[15:8] = i_data;
                fvgp_pkg::OFS_LAST:   n_sig[7:0]  = i_data;
                default: ;
            endcase

            if (i_first_sector) begin
                n_awaiting = 1'b0;
            end

            if (i_offset == fvgp_pkg::OFS_LAST) begin
                o_push             = 1'b1;
                o_job.id16         = n_id16;
                o_job.id32         = n_id32;
                o_job.jump         = n_jump;
                o_job.sec_bytes    = n_sec_bytes;
                o_job.sig          = n_sig;
                o_job.spc          = n_spc;
                o_job.rsvd         = n_rsvd;
                o_job.fat_copies   = n_fat_copies;
                o_job.root_entries = n_root_entries;
                o_job.fat16_size   = n_fat16_size;
                o_job.fat32_size   = n_fat32_size;
                o_job.root_clus    = n_root_clus;
                if (!i_first_sector) begin
                    n_awaiting      = 1'b0;
                    o_job.is_volume = 1'b1;
                    o_job.lba       = r_part_lba;
                end else if (n_id16 || n_id32) begin
                    o_job.is_volume = 1'b1;
                    o_job.lba       = '0;
                end else if (n_sig == fvgp_pkg::BOOT_SIG) begin
                    n_part_lba   = n_mbr_lba;
                    n_awaiting   = 1'b1;
                    o_job.status = fvgp_pkg::ST_READ_BOOT;
                    o_job.lba    = n_mbr_lba;
                end else begin
                    o_job.status = fvgp_pkg::ST_BAD_MBR;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting     <= 1'b0;
            r_part_lba     <= '0;
            r_id16         <= 1'b1;
            r_id32         <= 1'b1;
            r_jump         <= '0;
            r_sec_bytes    <= '0;
            r_sig          <= '0;
            r_spc          <= '0;
            r_rsvd         <= '0;
            r_fat_copies   <= '0;
            r_root_entries <= '0;
            r_fat16_size   <= '0;
            r_fat32_size   <= '0;
            r_root_clus    <= '0;
            r_mbr_lba      <= '0;
        end else begin
            r_awaiting     <= n_awaiting;
            r_part_lba     <= n_part_lba;
            r_id16         <= n_id16;
            r_id32         <= n_id32;
            r_jump         <= n_jump;
            r_sec_bytes    <= n_sec_bytes;
            r_sig          <= n_sig;
            r_spc          <= n_spc;
            r_rsvd         <= n_rsvd;
            r_fat_copies   <= n_fat_copies;
            r_root_entries <= n_root_entries;
            r_fat16_size   <= n_fat16_size;
            r_fat32_size   <= n_fat32_size;
            r_root_clus    <= n_root_clus;
            r_mbr_lba      <= n_mbr_lba;
        end
    end

endmodule

### src/fvgp_queue.sv
// Small job queue that decouples the byte capture front end from the geometry back end.
module fvgp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fvgp_pkg::t_job     i_job,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output fvgp_pkg::t_job     o_job
);

    fvgp_pkg::t_job                  r_mem [fvgp_pkg::QDEPTH];
    logic [fvgp_pkg::QPTR_W-1:0]     r_wptr, r_rptr;
    logic [fvgp_pkg::QCNT_W-1:0]     r_count;
    logic                            w_push, w_pop;

    assign o_full  = (r_count == fvgp_pkg::QCNT_W'(fvgp_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/fvgp_back.sv
// Back end: checks the boot sector, computes the volume geometry and holds the result beat.
module fvgp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  fvgp_pkg::t_job     i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic [31:0]        o_next_lba,
    output logic               o_is_fat32,
    output logic [7:0]         o_clus_sectors,
    output logic [7:0]         o_clus_mask,
    output logic [31:0]        o_fat_lba,
    output logic [31:0]        o_data_lba,
    output logic [31:0]        o_root_dir_start,
    output logic [27:0]        o_root_dir_cluster,
    output logic [12:0]        o_root_dir_sectors,
    output logic [15:0]        o_root_ents
);

    logic        r_s1_valid;
    logic [2:0]  r_s1_status;
    logic        r_s1_is32;
    logic [7:0]  r_s1_spc;
    logic [31:0] r_s1_lba;
    logic [31:0] r_s1_fat_st;
    logic [31:0] r_s1_p1;
    logic [31:0] r_s1_p2;
    logic [12:0] r_s1_rsec;
    logic [15:0] r_s1_dent;
    logic [27:0] r_s1_rclus;

    logic        w_s1_ready, w_s2_ready;
    logic [2:0]  w_status;
    logic [31:0] w_tsize;
    logic [39:0] w_p1, w_p2;
    logic [16:0] w_dent16_up;
    logic [31:0] w_sum1;

    assign w_s2_ready = !o_valid || i_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign o_pop      = i_q_valid && w_s1_ready;

    always_comb begin
        if (!i_job.is_volume) begin
            w_status = i_job.status;
        end else if (!i_job.id32 && !i_job.id16) begin
            w_status = fvgp_pkg::ST_NO_ID;
        end else if (i_job.sig != fvgp_pkg::BOOT_SIG) begin
            w_status = fvgp_pkg::ST_BAD_SIG;
        end else if (i_job.jump != fvgp_pkg::JMP_NEAR && i_job.jump != fvgp_pkg::JMP_SHORT) begin
            w_status = fvgp_pkg::ST_BAD_JUMP;
        end else if (i_job.sec_bytes != fvgp_pkg::SECTOR_512) begin
            w_status = fvgp_pkg::ST_BAD_SIZE;
        end else begin
            w_status = fvgp_pkg::ST_FOUND;
        end
    end

    assign w_tsize     = i_job.id32 ? i_job.fat32_size : {16'd0, i_job.fat16_size};
    assign w_p1        = {32'd0, i_job.fat_copies} * {8'd0, w_tsize};
    assign w_p2        = {8'd0, {4'd0, i_job.root_clus} - fvgp_pkg::FIRST_CLUSTER}
                         * {32'd0, i_job.spc};
    assign w_dent16_up = {1'b0, i_job.root_entries} + 17'd15;

    always_ff @(posedge i_clk) begin
        if (w_s1_ready) begin
            r_s1_status <= w_status;
            r_s1_is32   <= i_job.id32;
            r_s1_spc    <= i_job.spc;
            r_s1_lba    <= i_job.lba;
            r_s1_fat_st <= i_job.lba + {16'd0, i_job.rsvd};
            r_s1_p1     <= w_p1[31:0];
            r_s1_p2     <= w_p2[31:0];
            r_s1_rclus  <= i_job.root_clus;
            if (i_job.id32) begin
                r_s1_rsec <= {5'd0, i_job.spc};
                r_s1_dent <= {4'd0, i_job.spc, 4'd0};
            end else begin
                r_s1_rsec <= w_dent16_up[16:4];
                r_s1_dent <= i_job.root_entries;
            end
        end
    end

    assign w_sum1 = r_s1_fat_st + r_s1_p1;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_s2_ready) begin
            o_status           <= r_s1_status;
            o_next_lba         <= (r_s1_status == fvgp_pkg::ST_READ_BOOT) ? r_s1_lba : '0;
            o_is_fat32         <= '0;
            o_clus_sectors     <= '0;
            o_clus_mask        <= '0;
            o_fat_lba          <= '0;
            o_data_lba         <= '0;
            o_root_dir_start   <= '0;
            o_root_dir_cluster <= '0;
            o_root_dir_sectors <= '0;
            o_root_ents        <= '0;
            if (r_s1_status == fvgp_pkg::ST_FOUND) begin
                o_is_fat32         <= r_s1_is32;
                o_clus_sectors     <= r_s1_spc;
                o_clus_mask        <= r_s1_spc - 8'd1;
                o_fat_lba          <= r_s1_fat_st;
                o_root_dir_sectors <= r_s1_rsec;
                o_root_ents        <= r_s1_dent;
                if (r_s1_is32) begin
                    o_data_lba         <= w_sum1;
                    o_root_dir_start   <= w_sum1 + r_s1_p2;
                    o_root_dir_cluster <= r_s1_rclus;
                end else begin
                    o_data_lba       <= w_sum1 + {19'd0, r_s1_rsec};
                    o_root_dir_start <= w_sum1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_q_valid;
            end
            if (w_s2_ready) begin
                o_valid <= r_s1_valid;
            end
        end
    end

endmodule

### verif/fat_volume_geometry_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the FAT volume geometry parser, driven with whole and partial sectors.
module fat_volume_geometry_parser_tb;

    localparam int CYCLE_LIMIT   = 40000;
    localparam int MAX_PRINTS    = 40;
    localparam int PHASE_BYTES   = 48;
    localparam int PHASE_RESULTS = 1;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 12;

    localparam logic [8:0] OFS_BPS       = 9'd11;
    localparam logic [8:0] OFS_SPC       = 9'd13;
    localparam logic [8:0] OFS_RSVD      = 9'd14;
    localparam logic [8:0] OFS_NFATS     = 9'd16;
    localparam logic [8:0] OFS_ROOT_ENT  = 9'd17;
    localparam logic [8:0] OFS_FAT16_SZ  = 9'd22;
    localparam logic [8:0] OFS_FAT32_SZ  = 9'h024;
    localparam logic [8:0] OFS_ROOT_CLUS = 9'h02C;
    localparam logic [8:0] OFS_MBR_LBA   = 9'h1C6;

    typedef enum int {FLAW_NONE, FLAW_NO_ID, FLAW_SIG, FLAW_JUMP, FLAW_SIZE} t_flaw;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] next_lba;
        logic        is_fat32;
        logic [7:0]  clus_sectors;
        logic [7:0]  clus_mask;
        logic [31:0] fat_lba;
        logic [31:0] data_lba;
        logic [31:0] root_dir_start;
        logic [27:0] root_dir_cluster;
        logic [12:0] root_dir_sectors;
        logic [15:0] root_ents;
        logic        ready_res;
    } t_volume_info;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_first_sector = 1'b0;
    logic [8:0]  i_offset = '0;
    logic [7:0]  i_data = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [31:0] o_next_lba;
    logic        o_is_fat32;
    logic [7:0]  o_clus_sectors;
    logic [7:0]  o_clus_mask;
    logic [31:0] o_fat_lba;
    logic [31:0] o_data_lba;
    logic [31:0] o_root_dir_start;
    logic [27:0] o_root_dir_cluster;
    logic [12:0] o_root_dir_sectors;
    logic [15:0] o_root_ents;
    logic        o_ready_res;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_ready = 1'b0;
    int cycle_count = 0;
    int mismatches = 0;
    int bytes_used = 0;
    int results_made = 0;

    logic [7:0] sector_img [512];
    t_volume_info expected_geom [$];
    t_volume_info want;

    logic        boot_pending = 1'b0;
    logic [31:0] boot_lba = '0;
    logic        id16_seen = 1'b1;
    logic        id32_seen = 1'b1;
    logic [7:0]  jump_byte = '0;
    logic [15:0] bytes_per_sector = '0;
    logic [15:0] sig_word = '0;
    logic [7:0]  spc_byte = '0;
    logic [15:0] reserved_cnt = '0;
    logic [7:0]  fat_count = '0;
    logic [15:0] root_entries = '0;
    logic [15:0] fat16_sectors = '0;
    logic [31:0] fat32_sectors = '0;
    logic [31:0] root_cluster_raw = '0;
    logic [31:0] mbr_lba = '0;

    fat_volume_geometry_parser i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_first_sector     (i_first_sector),
        .i_offset           (i_offset),
        .i_data             (i_data),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_next_lba         (o_next_lba),
        .o_is_fat32         (o_is_fat32),
        .o_clus_sectors     (o_clus_sectors),
        .o_clus_mask        (o_clus_mask),
        .o_fat_lba          (o_fat_lba),
        .o_data_lba         (o_data_lba),
        .o_root_dir_start   (o_root_dir_start),
        .o_root_dir_cluster (o_root_dir_cluster),
        .o_root_dir_sectors (o_root_dir_sectors),
        .o_root_ents        (o_root_ents),
        .o_ready_res        (o_ready_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_ready) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] wanted);
        if (mismatches < MAX_PRINTS)
            $display("ERROR at %0t ns: %s is %0h, expected %0h", $time, field, got, wanted);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_geom.size() == 0) begin
                report_mismatch("status of a result beat with nothing pending",
                                32'(o_status), '0);
            end else begin
                want = expected_geom.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_next_lba !== want.next_lba)
                    report_mismatch("next_lba", o_next_lba, want.next_lba);
                if (o_is_fat32 !== want.is_fat32)
                    report_mismatch("is_fat32", 32'(o_is_fat32), 32'(want.is_fat32));
                if (o_clus_sectors !== want.clus_sectors)
                    report_mismatch("clus_sectors", 32'(o_clus_sectors),
                                    32'(want.clus_sectors));
                if (o_clus_mask !== want.clus_mask)
                    report_mismatch("clus_mask", 32'(o_clus_mask), 32'(want.clus_mask));
                if (o_fat_lba !== want.fat_lba)
                    report_mismatch("fat_lba", o_fat_lba, want.fat_lba);
                if (o_data_lba !== want.data_lba)
                    report_mismatch("data_lba", o_data_lba, want.data_lba);
                if (o_root_dir_start !== want.root_dir_start)
                    report_mismatch("root_dir_start", o_root_dir_start, want.root_dir_start);
                if (o_root_dir_cluster !== want.root_dir_cluster)
                    report_mismatch("root_dir_cluster", 32'(o_root_dir_cluster),
                                    32'(want.root_dir_cluster));
                if (o_root_dir_sectors !== want.root_dir_sectors)
                    report_mismatch("root_dir_sectors", 32'(o_root_dir_sectors),
                                    32'(want.root_dir_sectors));
                if (o_root_ents !== want.root_ents)
                    report_mismatch("root_ents", 32'(o_root_ents), 32'(want.root_ents));
                if (o_ready_res !== want.ready_res)
                    report_mismatch("ready_res", 32'(o_ready_res), 32'(want.ready_res));
            end
        end
    end

    function automatic t_volume_info volume_geometry(input logic [31:0] base);
        t_volume_info r;
        logic is32;
        logic [31:0] spc, fat_lba, data_lba, root_lba, rclus, rsecs, dents;
        r = '0;
        r.ready_res = 1'b1;
        if (id32_seen) begin
            is32 = 1'b1;
        end else if (id16_seen) begin
            is32 = 1'b0;
        end else begin
            r.status = fvgp_pkg::ST_NO_ID;
            return r;
        end
        if (sig_word != fvgp_pkg::BOOT_SIG) begin
            r.status = fvgp_pkg::ST_BAD_SIG;
            return r;
        end
        if (jump_byte != fvgp_pkg::JMP_NEAR && jump_byte != fvgp_pkg::JMP_SHORT) begin
            r.status = fvgp_pkg::ST_BAD_JUMP;
            return r;
        end
        if (bytes_per_sector != fvgp_pkg::SECTOR_512) begin
            r.status = fvgp_pkg::ST_BAD_SIZE;
            return r;
        end
        spc = {24'd0, spc_byte};
        fat_lba = base + {16'd0, reserved_cnt};
        if (is32) begin
            dents = spc << 4;
            rsecs = spc;
            data_lba = fat_lba + {24'd0, fat_count} * fat32_sectors;
            rclus = {4'd0, root_cluster_raw[27:0]};
            root_lba = (rclus - fvgp_pkg::FIRST_CLUSTER) * spc + data_lba;
        end else begin
            dents = {16'd0, root_entries};
            rsecs = ((dents << 5) + 32'd511) >> 9;
            root_lba = fat_lba + {24'd0, fat_count} * {16'd0, fat16_sectors};
            rclus = '0;
            data_lba = root_lba + rsecs;
        end
        r.status = fvgp_pkg::ST_FOUND;
        r.is_fat32 = is32;
        r.clus_sectors = spc_byte;
        r.clus_mask = spc_byte - 8'd1;
        r.fat_lba = fat_lba;
        r.data_lba = data_lba;
        r.root_dir_start = root_lba;
        r.root_dir_cluster = rclus[27:0];
        r.root_dir_sectors = rsecs[12:0];
        r.root_ents = dents[15:0];
        return r;
    endfunction

    task automatic capture_byte(input logic [8:0] ofs, input logic [7:0] dat);
        int k;
        if (ofs == fvgp_pkg::OFS_FIRST) begin
            id16_seen = 1'b1;
            id32_seen = 1'b1;
            jump_byte = dat;
        end
        if (ofs >= fvgp_pkg::ID16_OFS && ofs < fvgp_pkg::ID16_OFS + 9'd8) begin
            k = int'(ofs - fvgp_pkg::ID16_OFS);
            if (dat != fvgp_pkg::ID16_TEXT[63 - 8 * k -: 8]) id16_seen = 1'b0;
        end
        if (ofs >= fvgp_pkg::ID32_OFS && ofs < fvgp_pkg::ID32_OFS + 9'd8) begin
            k = int'(ofs - fvgp_pkg::ID32_OFS);
            if (dat != fvgp_pkg::ID32_TEXT[63 - 8 * k -: 8]) id32_seen = 1'b0;
        end
        if (ofs >= OFS_FAT32_SZ && ofs < OFS_FAT32_SZ + 9'd4)
            fat32_sectors[8 * int'(ofs - OFS_FAT32_SZ) +: 8] = dat;
        if (ofs >= OFS_ROOT_CLUS && ofs < OFS_ROOT_CLUS + 9'd4)
            root_cluster_raw[8 * int'(ofs - OFS_ROOT_CLUS) +: 8] = dat;
        if (ofs >= OFS_MBR_LBA && ofs < OFS_MBR_LBA + 9'd4)
            mbr_lba[8 * int'(ofs - OFS_MBR_LBA) +: 8] = dat;
        case (ofs)
            OFS_BPS:              bytes_per_sector[7:0] = dat;
            OFS_BPS + 9'd1:       bytes_per_sector[15:8] = dat;
            OFS_SPC:              spc_byte = dat;
            OFS_RSVD:             reserved_cnt[7:0] = dat;
            OFS_RSVD + 9'd1:      reserved_cnt[15:8] = dat;
            OFS_NFATS:            fat_count = dat;
            OFS_ROOT_ENT:         root_entries[7:0] = dat;
            OFS_ROOT_ENT + 9'd1:  root_entries[15:8] = dat;
            OFS_FAT16_SZ:         fat16_sectors[7:0] = dat;
            OFS_FAT16_SZ + 9'd1:  fat16_sectors[15:8] = dat;
            fvgp_pkg::OFS_SIG_HI: sig_word[15:8] = dat;
            fvgp_pkg::OFS_LAST:   sig_word[7:0] = dat;
            default: ;
        endcase
    endtask

    task automatic predict_geometry(input logic first, input logic [8:0] ofs,
                                    input logic [7:0] dat);
        t_volume_info r;
        if (first) begin
            boot_pending = 1'b0;
        end else if (!boot_pending) begin
            return;
        end
        bytes_used++;
        capture_byte(ofs, dat);
        if (ofs != fvgp_pkg::OFS_LAST) return;
        r = '0;
        r.ready_res = 1'b1;
        if (!first) begin
            boot_pending = 1'b0;
            r = volume_geometry(boot_lba);
        end else if (id16_seen || id32_seen) begin
            r = volume_geometry('0);
        end else if (sig_word == fvgp_pkg::BOOT_SIG) begin
            boot_lba = mbr_lba;
            boot_pending = 1'b1;
            r.status = fvgp_pkg::ST_READ_BOOT;
            r.next_lba = boot_lba;
        end else begin
            r.status = fvgp_pkg::ST_BAD_MBR;
        end
        expected_geom.push_back(r);
        results_made++;
    endtask

    task automatic send_beat(input logic first, input logic [8:0] ofs, input logic [7:0] dat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_first_sector <= first;
        i_offset <= ofs;
        i_data <= dat;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_geometry(first, ofs, dat);
    endtask

    function automatic bit key_offset(input logic [8:0] o);
        return o == fvgp_pkg::OFS_FIRST || (o >= OFS_BPS && o <= OFS_ROOT_ENT + 9'd1) ||
               o == OFS_FAT16_SZ || o == OFS_FAT16_SZ + 9'd1 ||
               (o >= OFS_FAT32_SZ && o < OFS_FAT32_SZ + 9'd4) ||
               (o >= OFS_ROOT_CLUS && o < OFS_ROOT_CLUS + 9'd4) ||
               (o >= fvgp_pkg::ID16_OFS && o < fvgp_pkg::ID16_OFS + 9'd8) ||
               (o >= fvgp_pkg::ID32_OFS && o < fvgp_pkg::ID32_OFS + 9'd8) ||
               (o >= OFS_MBR_LBA && o < OFS_MBR_LBA + 9'd4) || o >= fvgp_pkg::OFS_SIG_HI;
    endfunction

    // A compact sector carries the captured fields plus a sprinkling of other bytes.
    task automatic send_sector(input logic first, input int stop_at);
        int k;
        for (k = 0; k < stop_at; k++) begin
            if (key_offset(k[8:0]) || $urandom_range(63) == 0)
                send_beat(first, k[8:0], sector_img[k]);
        end
    endtask

    task automatic put_le(input logic [8:0] ofs, input int n, input logic [31:0] v);
        int k;
        for (k = 0; k < n; k++) sector_img[int'(ofs) + k] = v[8 * k +: 8];
    endtask

    task automatic put_text(input logic [8:0] ofs, input logic [63:0] t);
        int k;
        for (k = 0; k < 8; k++) sector_img[int'(ofs) + k] = t[63 - 8 * k -: 8];
    endtask

    task automatic fill_random();
        int k;
        for (k = 0; k < 512; k++) sector_img[k] = 8'($urandom_range(255));
    endtask

    task automatic make_boot(input logic is32, input t_flaw flaw);
        fill_random();
        sector_img[fvgp_pkg::OFS_FIRST] = $urandom_range(1) ? fvgp_pkg::JMP_NEAR
                                                             : fvgp_pkg::JMP_SHORT;
        put_le(OFS_BPS, 2, {16'd0, fvgp_pkg::SECTOR_512});
        case ($urandom_range(3))
            0: sector_img[OFS_SPC] = 8'h00;
            1: sector_img[OFS_SPC] = 8'hFF;
            default: ;
        endcase
        if (is32) begin
            put_text(fvgp_pkg::ID32_OFS, fvgp_pkg::ID32_TEXT);
            sector_img[fvgp_pkg::ID16_OFS] = 8'h20;
        end else begin
            put_text(fvgp_pkg::ID16_OFS, fvgp_pkg::ID16_TEXT);
            sector_img[fvgp_pkg::ID32_OFS] = 8'h20;
        end
        sector_img[fvgp_pkg::OFS_SIG_HI] = fvgp_pkg::BOOT_SIG[15:8];
        sector_img[fvgp_pkg::OFS_LAST] = fvgp_pkg::BOOT_SIG[7:0];
        case (flaw)
            FLAW_NO_ID: begin
                sector_img[fvgp_pkg::ID16_OFS] = 8'h20;
                sector_img[fvgp_pkg::ID32_OFS] = 8'h20;
            end
            FLAW_SIG: sector_img[fvgp_pkg::OFS_SIG_HI + 9'($urandom_range(1))] ^=
                          8'h01 << $urandom_range(7);
            FLAW_JUMP: begin
                sector_img[fvgp_pkg::OFS_FIRST] = 8'($urandom_range(255));
                if (sector_img[fvgp_pkg::OFS_FIRST] == fvgp_pkg::JMP_NEAR ||
                    sector_img[fvgp_pkg::OFS_FIRST] == fvgp_pkg::JMP_SHORT)
                    sector_img[fvgp_pkg::OFS_FIRST] ^= 8'h10;
            end
            FLAW_SIZE: put_le(OFS_BPS, 2, {16'd0, fvgp_pkg::SECTOR_512 ^
                                                  16'($urandom_range(16'hFFFF, 1))});
            default: ;
        endcase
    endtask

    task automatic make_mbr(input logic [31:0] lba, input logic sig_ok);
        fill_random();
        sector_img[fvgp_pkg::ID16_OFS] = 8'h20;
        sector_img[fvgp_pkg::ID32_OFS] = 8'h20;
        put_le(OFS_MBR_LBA, 4, lba);
        sector_img[fvgp_pkg::OFS_SIG_HI] = fvgp_pkg::BOOT_SIG[15:8];
        sector_img[fvgp_pkg::OFS_LAST] = fvgp_pkg::BOOT_SIG[7:0];
        if (!sig_ok)
            sector_img[fvgp_pkg::OFS_SIG_HI + 9'($urandom_range(1))] ^=
                8'h01 << $urandom_range(7);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic test_fat16_volume();
        make_boot(1'b0, FLAW_NONE);
        sector_img[OFS_SPC] = 8'h00;
        put_le(OFS_RSVD, 2, 32'hFFFF);
        sector_img[OFS_NFATS] = 8'hFF;
        put_le(OFS_ROOT_ENT, 2, 32'hFFFF);
        put_le(OFS_FAT16_SZ, 2, 32'hFFFF);
        send_sector(1'b1, 512);
        make_boot(1'b0, FLAW_NONE);
        sector_img[fvgp_pkg::OFS_FIRST] = fvgp_pkg::JMP_SHORT;
        sector_img[OFS_SPC] = 8'h01;
        put_le(OFS_RSVD, 2, 32'h0);
        sector_img[OFS_NFATS] = 8'h00;
        put_le(OFS_ROOT_ENT, 2, 32'h0);
        put_le(OFS_FAT16_SZ, 2, 32'h0);
        send_sector(1'b1, 512);
    endtask

    task automatic test_fat32_volume();
        make_boot(1'b1, FLAW_NONE);
        sector_img[fvgp_pkg::OFS_FIRST] = fvgp_pkg::JMP_NEAR;
        sector_img[OFS_SPC] = 8'hFF;
        put_le(OFS_RSVD, 2, 32'h0);
        sector_img[OFS_NFATS] = 8'hFF;
        put_le(OFS_FAT32_SZ, 4, 32'hFFFF_FFFF);
        put_le(OFS_ROOT_CLUS, 4, 32'h0);
        send_sector(1'b1, 512);
        // Both identifiers present: FAT32 takes precedence.
        make_boot(1'b1, FLAW_NONE);
        put_text(fvgp_pkg::ID16_OFS, fvgp_pkg::ID16_TEXT);
        put_le(OFS_ROOT_CLUS, 4, 32'hFFFF_FFFF);
        send_sector(1'b1, 512);
    endtask

    task automatic test_partition_boot();
        make_mbr(32'hFFFF_FFFF, 1'b1);
        send_sector(1'b1, 512);
        make_boot(1'b1, FLAW_NONE);
        put_le(OFS_RSVD, 2, 32'hFFFF);
        send_sector(1'b0, 512);
    endtask

    task automatic test_check_failures();
        int f;
        make_mbr($urandom, 1'b0);
        send_sector(1'b1, 512);
        make_mbr($urandom, 1'b1);
        send_sector(1'b1, 512);
        make_boot(1'($urandom_range(1)), FLAW_NO_ID);
        send_sector(1'b0, 512);
        for (f = FLAW_SIG; f <= FLAW_SIZE; f++) begin
            make_boot(1'($urandom_range(1)), t_flaw'(f));
            send_sector(1'b1, 512);
        end
    endtask

    task automatic test_stray_boot_bytes();
        send_beat(1'b0, fvgp_pkg::OFS_FIRST, 8'h00);
        send_beat(1'b0, fvgp_pkg::ID16_OFS, 8'h00);
        send_beat(1'b0, fvgp_pkg::OFS_LAST, 8'hFF);
        send_beat(1'b1, fvgp_pkg::OFS_LAST, fvgp_pkg::BOOT_SIG[7:0]);
    endtask

    task automatic test_cancelled_wait();
        make_mbr($urandom, 1'b1);
        send_sector(1'b1, 512);
        make_boot(1'b1, FLAW_NONE);
        send_sector(1'b0, $urandom_range(100, 400));
        make_boot(1'b0, FLAW_NONE);
        send_sector(1'b1, 512);
        send_beat(1'b0, fvgp_pkg::OFS_LAST, fvgp_pkg::BOOT_SIG[7:0]);
    endtask

    task automatic test_repeated_offsets();
        make_boot(1'b0, FLAW_NONE);
        send_sector(1'b1, 512);
        send_beat(1'b1, fvgp_pkg::OFS_LAST, fvgp_pkg::BOOT_SIG[7:0]);
        send_beat(1'b1, fvgp_pkg::OFS_SIG_HI, 8'h00);
        send_beat(1'b1, fvgp_pkg::OFS_LAST, fvgp_pkg::BOOT_SIG[7:0]);
        send_beat(1'b1, fvgp_pkg::OFS_SIG_HI, fvgp_pkg::BOOT_SIG[15:8]);
        send_beat(1'b1, OFS_BPS + 9'd1, 8'h04);
        send_beat(1'b1, fvgp_pkg::OFS_LAST, fvgp_pkg::BOOT_SIG[7:0]);
    endtask

    task automatic random_scenario();
        int pick;
        t_flaw flaw;
        pick = $urandom_range(99);
        flaw = ($urandom_range(3) == 0) ? t_flaw'($urandom_range(FLAW_SIZE, FLAW_NO_ID))
                                         : FLAW_NONE;
        if (pick < 30) begin
            make_boot(1'($urandom_range(1)), flaw);
            send_sector(1'b1, 512);
        end else if (pick < 70) begin
            make_mbr($urandom, 1'b1);
            send_sector(1'b1, 512);
            make_boot(1'($urandom_range(1)), flaw);
            send_sector(1'b0, 512);
        end else if (pick < 80) begin
            make_mbr($urandom, 1'b1);
            send_sector(1'b1, 512);
            make_boot(1'($urandom_range(1)), flaw);
            send_sector(1'b0, $urandom_range(1, 511));
        end else if (pick < 88) begin
            make_mbr($urandom, 1'($urandom_range(1)));
            send_sector(1'b1, 512);
        end else begin
            repeat ($urandom_range(1, 12))
                send_beat(1'($urandom_range(1)), 9'($urandom_range(511)),
                          8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_traffic();
        int start_bytes, start_results;
        start_bytes = bytes_used;
        start_results = results_made;
        while (bytes_used - start_bytes < PHASE_BYTES ||
               results_made - start_results < PHASE_RESULTS)
            random_scenario();
    endtask

    // The result side is held off while offset-511 beats keep arriving back to back.
    task automatic test_full_stall();
        int k;
        fork
            begin
                hold_ready <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_ready <= 1'b0;
            end
        join_none
        for (k = 0; k < 24; k++)
            send_beat(1'b1, fvgp_pkg::OFS_LAST, 8'($urandom_range(255)));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(33, 74);
        test_fat16_volume();
        test_fat32_volume();
        test_partition_boot();
        test_stray_boot_bytes();
        set_idling(74, 33);
        test_check_failures();
        test_cancelled_wait();
        set_idling(0, 0);
        test_repeated_offsets();
        test_full_stall();
        test_random_traffic();
        i_valid <= 1'b0;
        while (expected_geom.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
